FILE: sv/ppp_pkg.sv
// Shared types and constants for the pinhole point projection pipeline.
package ppp_pkg;

    // Widths fixed by the channel fields and the 64-bit accumulator.
    localparam int SUM_W       = 64;
    localparam int MAG_W       = SUM_W + 2;
    localparam int QMAX        = 25;
    localparam int HALF_W      = 32;
    localparam int POINT_FLD_W = 24;
    localparam int PIXEL_FLD_W = 16;
    localparam int DIM_W       = 15;
    localparam int POINT_FRAC  = 10;
    localparam int NUM_PAIRS   = 6;
    localparam int CFG_IDX_W   = 3;

    // Parameter defaults.
    localparam int COEF_WIDTH_DEF  = 32;
    localparam int POINT_WIDTH_DEF = 24;
    localparam int PIXEL_WIDTH_DEF = 16;

    // Reset values of the image size.
    localparam logic [DIM_W-1:0] WIDTH_RST  = 15'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 15'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR0  = 3'd0,
        CFG_PAIR1  = 3'd1,
        CFG_PAIR2  = 3'd2,
        CFG_PAIR3  = 3'd3,
        CFG_PAIR4  = 3'd4,
        CFG_PAIR5  = 3'd5,
        CFG_WIDTH  = 3'd6,
        CFG_HEIGHT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POINT_FLD_W-1:0] point_x;
        logic signed [POINT_FLD_W-1:0] point_y;
        logic signed [POINT_FLD_W-1:0] point_z;
    } t_point_in;

    typedef struct packed {
        logic signed [PIXEL_FLD_W-1:0] pixel_u;
        logic signed [PIXEL_FLD_W-1:0] pixel_v;
        logic                          in_image;
        logic                          behind_camera;
    } t_pixel_out;

    typedef logic [NUM_PAIRS-1:0][2*HALF_W-1:0] t_coefs;

    typedef struct packed {
        logic [SUM_W-1:0] nu;
        logic [SUM_W-1:0] nv;
        logic [SUM_W-1:0] d;
    } t_sums;

    // Beat handed from cell to cell of the divider chain.
    typedef struct packed {
        logic [MAG_W-1:0] rem_u;
        logic [MAG_W-1:0] rem_v;
        logic [QMAX-1:0]  quo_u;
        logic [QMAX-1:0]  quo_v;
        logic [SUM_W-1:0] div;
        logic             neg_u;
        logic             neg_v;
        logic             ovf_u;
        logic             ovf_v;
        logic             behind;
    } t_div;

endpackage

FILE: sv/pinhole_point_projection.sv
// Top level: lidar point to pixel projection with a divider cell chain.
//
//  channel | valid   | stall   | payload  | beat
//  point   | i_valid | o_stall | i_point  | x, y, z
//  pixel   | o_valid | i_stall | o_pixel  | u, v, in_image, behind_camera
//  config  | i_cfg_we| -       | i_cfg_data | index i_cfg_index
//
// One point enters per cycle unless stalled; a point passes max(PIXEL_WIDTH, 15) + 7
// register stages, 23 at default (input, product, sum, numerator, magnitude, one
// cell per quotient bit, output), set by the length of the divider cell chain.
// Reset is synchronous; it clears all valid bits and resets the configuration registers.
// A stall holds only the stages that are full; bubbles close up behind it.
module pinhole_point_projection #(
    parameter int COEF_WIDTH  = ppp_pkg::COEF_WIDTH_DEF,
    parameter int POINT_WIDTH = ppp_pkg::POINT_WIDTH_DEF,
    parameter int PIXEL_WIDTH = ppp_pkg::PIXEL_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  ppp_pkg::t_point_in              i_point,
    output logic                            o_valid,
    input  logic                            i_stall,
    output ppp_pkg::t_pixel_out             o_pixel,
    input  logic                            i_cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [2*ppp_pkg::HALF_W-1:0]    i_cfg_data
);
    localparam int QB = (PIXEL_WIDTH > ppp_pkg::DIM_W ? PIXEL_WIDTH : ppp_pkg::DIM_W) + 1;
    localparam int SW = QB + 2;

    ppp_pkg::t_coefs          r_coefs;
    logic [ppp_pkg::DIM_W-1:0] r_width;
    logic [ppp_pkg::DIM_W-1:0] r_height;
    logic                     r_in_valid;
    ppp_pkg::t_point_in       r_in;
    logic                     r_out_valid;
    ppp_pkg::t_pixel_out      r_out;
    ppp_pkg::t_pixel_out      n_out;
    logic                     en_in;
    logic                     en_mac;
    logic                     en_out;
    logic                     en_prep;
    logic                     mac_valid;
    ppp_pkg::t_sums           mac_sums;
    logic [QB-1:0]            ce_chain;
    logic [QB:0]              cv;
    ppp_pkg::t_div            cd [QB+1];

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs  <= '0;
            r_width  <= ppp_pkg::WIDTH_RST;
            r_height <= ppp_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (ppp_pkg::t_cfg_idx'(i_cfg_index))
                ppp_pkg::CFG_PAIR0,
                ppp_pkg::CFG_PAIR1,
                ppp_pkg::CFG_PAIR2,
                ppp_pkg::CFG_PAIR3,
                ppp_pkg::CFG_PAIR4,
                ppp_pkg::CFG_PAIR5: r_coefs[i_cfg_index] <= i_cfg_data;
                ppp_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[ppp_pkg::DIM_W-1:0];
                ppp_pkg::CFG_HEIGHT: r_height <= i_cfg_data[ppp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    assign en_in   = !r_in_valid || en_mac;
    assign o_stall = !en_in;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en_in) begin
            r_in_valid <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en_in) r_in <= i_point;
    end

    ppp_mac #(
        .COEF_WIDTH  (COEF_WIDTH),
        .POINT_WIDTH (POINT_WIDTH)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_point   (r_in),
        .i_coefs   (r_coefs),
        .i_next_en (en_prep),
        .o_en      (en_mac),
        .o_valid   (mac_valid),
        .o_sums    (mac_sums)
    );

    ppp_div_prep #(
        .QB (QB)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (mac_valid),
        .i_sums    (mac_sums),
        .i_next_en (ce_chain[0]),
        .o_en      (en_prep),
        .o_valid   (cv[0]),
        .o_data    (cd[0])
    );

    // Divider chain, most significant quotient bit first.
    genvar j;
    generate
        for (j = 0; j < QB; j++) begin : g_cell
            logic nen;
            if (j == QB - 1) begin : g_last
                assign nen = en_out;
            end else begin : g_mid
                assign nen = ce_chain[j+1];
            end
            ppp_div_cell #(
                .K (QB - 1 - j)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_valid   (cv[j]),
                .i_data    (cd[j]),
                .i_next_en (nen),
                .o_en      (ce_chain[j]),
                .o_valid   (cv[j+1]),
                .o_data    (cd[j+1])
            );
        end
    endgenerate

    // Sign fix, saturation and bounds test.
    always_comb begin
        logic signed [SW-1:0]          qu;
        logic signed [SW-1:0]          qv;
        logic signed [SW-1:0]          hi;
        logic signed [SW-1:0]          lo;
        logic signed [PIXEL_WIDTH-1:0] pu;
        logic signed [PIXEL_WIDTH-1:0] pv;
        logic                          in_u;
        logic                          in_v;
        hi = SW'((1 << (PIXEL_WIDTH - 1)) - 1);
        lo = -hi - SW'(1);
        qu = SW'(cd[QB].quo_u[QB-1:0]);
        qv = SW'(cd[QB].quo_v[QB-1:0]);
        if (cd[QB].neg_u) qu = -(qu + SW'(cd[QB].rem_u != '0));
        if (cd[QB].neg_v) qv = -(qv + SW'(cd[QB].rem_v != '0));
        if (cd[QB].ovf_u)  pu = cd[QB].neg_u ? PIXEL_WIDTH'(lo) : PIXEL_WIDTH'(hi);
        else if (qu > hi)  pu = PIXEL_WIDTH'(hi);
        else if (qu < lo)  pu = PIXEL_WIDTH'(lo);
        else               pu = PIXEL_WIDTH'(qu);
        if (cd[QB].ovf_v)  pv = cd[QB].neg_v ? PIXEL_WIDTH'(lo) : PIXEL_WIDTH'(hi);
        else if (qv > hi)  pv = PIXEL_WIDTH'(hi);
        else if (qv < lo)  pv = PIXEL_WIDTH'(lo);
        else               pv = PIXEL_WIDTH'(qv);
        in_u = !cd[QB].ovf_u && !qu[SW-1] && (qu < $signed(SW'(r_width)));
        in_v = !cd[QB].ovf_v && !qv[SW-1] && (qv < $signed(SW'(r_height)));
        if (cd[QB].behind) begin
            n_out               = '0;
            n_out.behind_camera = 1'b1;
        end else begin
            n_out.pixel_u       = ppp_pkg::PIXEL_FLD_W'(pu);
            n_out.pixel_v       = ppp_pkg::PIXEL_FLD_W'(pv);
            n_out.in_image      = in_u && in_v;
            n_out.behind_camera = 1'b0;
        end
    end

    // Output register.
    assign en_out = !r_out_valid || !i_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= cv[QB];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en_out) r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out;

    // A point behind the camera reports no pixel.
    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel.behind_camera |->
            o_pixel.pixel_u == '0 && o_pixel.pixel_v == '0 && !o_pixel.in_image)
        else $error("behind-camera beat carries a pixel");

    // An empty input register never pushes back.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("stall raised with empty input stage");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid straight after reset");

    // A waiting result holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel))
        else $error("stalled result changed");
endmodule

FILE: sv/ppp_mac.sv
// Matrix times point: product stage followed by a row-sum stage.
module ppp_mac #(
    parameter int COEF_WIDTH  = ppp_pkg::COEF_WIDTH_DEF,
    parameter int POINT_WIDTH = ppp_pkg::POINT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ppp_pkg::t_point_in i_point,
    input  ppp_pkg::t_coefs   i_coefs,
    input  logic              i_next_en,
    output logic              o_en,
    output logic              o_valid,
    output ppp_pkg::t_sums    o_sums
);
    localparam int PROD_W = COEF_WIDTH + POINT_WIDTH;

    logic                          r_va;
    logic                          r_vb;
    logic [2:0][2:0][ppp_pkg::SUM_W-1:0] r_prod;
    logic [2:0][ppp_pkg::SUM_W-1:0]      r_trans;
    logic [2:0][ppp_pkg::SUM_W-1:0]      n_prod_row;
    logic [2:0][2:0][ppp_pkg::SUM_W-1:0] n_prod;
    logic [2:0][ppp_pkg::SUM_W-1:0]      n_trans;
    ppp_pkg::t_sums                r_sums;
    logic                          en_b;
    logic [2:0][ppp_pkg::HALF_W-1:0] pts;

    assign en_b = !r_vb || i_next_en;
    assign o_en = !r_va || en_b;

    // Widen each field to the half-word, then take the used low bits.
    assign pts[0] = ppp_pkg::HALF_W'($unsigned(i_point.point_x));
    assign pts[1] = ppp_pkg::HALF_W'($unsigned(i_point.point_y));
    assign pts[2] = ppp_pkg::HALF_W'($unsigned(i_point.point_z));

    // Form the nine products and the three translation terms.
    always_comb begin
        logic [ppp_pkg::HALF_W-1:0]      half;
        logic signed [COEF_WIDTH-1:0]    cf;
        logic signed [POINT_WIDTH-1:0]   pt;
        logic signed [PROD_W-1:0]        pr;
        n_prod  = '0;
        n_trans = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                half = (c % 2 == 1) ? i_coefs[r*2 + c/2][2*ppp_pkg::HALF_W-1:ppp_pkg::HALF_W]
                                    : i_coefs[r*2 + c/2][ppp_pkg::HALF_W-1:0];
                cf = half[COEF_WIDTH-1:0];
                if (c < 3) begin
                    pt = pts[c][POINT_WIDTH-1:0];
                    pr = cf * pt;
                    n_prod[r][c] = ppp_pkg::SUM_W'(pr);
                end else begin
                    n_trans[r] = ppp_pkg::SUM_W'(cf) << ppp_pkg::POINT_FRAC;
                end
            end
        end
    end

    // Add each row, wrapping at the accumulator width.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_prod_row[r] = r_prod[r][0] + r_prod[r][1] + r_prod[r][2] + r_trans[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (o_en) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_prod  <= n_prod;
            r_trans <= n_trans;
        end
        if (en_b) begin
            r_sums.nu <= n_prod_row[0];
            r_sums.nv <= n_prod_row[1];
            r_sums.d  <= n_prod_row[2];
        end
    end

    assign o_valid = r_vb;
    assign o_sums  = r_sums;
endmodule

FILE: sv/ppp_div_prep.sv
// Rounding numerators, divisor, signs and range check ahead of the divider chain.
module ppp_div_prep #(
    parameter int QB = 17
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ppp_pkg::t_sums i_sums,
    input  logic           i_next_en,
    output logic           o_en,
    output logic           o_valid,
    output ppp_pkg::t_div  o_data
);
    localparam int XW = ppp_pkg::MAG_W + QB;

    logic                              r_vc;
    logic                              r_vd;
    logic signed [ppp_pkg::MAG_W-1:0]  r_num_u;
    logic signed [ppp_pkg::MAG_W-1:0]  r_num_v;
    logic [ppp_pkg::SUM_W-1:0]         r_div;
    logic                              r_behind;
    ppp_pkg::t_div                     r_data;
    ppp_pkg::t_div                     n_data;
    logic signed [ppp_pkg::MAG_W-1:0]  n_num_u;
    logic signed [ppp_pkg::MAG_W-1:0]  n_num_v;
    logic signed [ppp_pkg::MAG_W-1:0]  d_ext;
    logic [XW-1:0]                     lim;
    logic                              en_d;

    assign en_d = !r_vd || i_next_en;
    assign o_en = !r_vc || en_d;

    // Round half up: floor((2n + d) / 2d).
    assign d_ext   = ppp_pkg::MAG_W'($signed(i_sums.d));
    assign n_num_u = (ppp_pkg::MAG_W'($signed(i_sums.nu)) <<< 1) + d_ext;
    assign n_num_v = (ppp_pkg::MAG_W'($signed(i_sums.nv)) <<< 1) + d_ext;

    // Take magnitudes and flag quotients beyond the chain's reach.
    assign lim = XW'(r_div) << QB;
    always_comb begin
        n_data       = '0;
        n_data.div   = r_div;
        n_data.neg_u = r_num_u[ppp_pkg::MAG_W-1];
        n_data.neg_v = r_num_v[ppp_pkg::MAG_W-1];
        n_data.rem_u = n_data.neg_u ? -r_num_u : r_num_u;
        n_data.rem_v = n_data.neg_v ? -r_num_v : r_num_v;
        n_data.ovf_u = XW'(n_data.rem_u) >= lim;
        n_data.ovf_v = XW'(n_data.rem_v) >= lim;
        n_data.behind = r_behind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (o_en) r_vc <= i_valid;
            if (en_d) r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_num_u  <= n_num_u;
            r_num_v  <= n_num_v;
            r_div    <= {i_sums.d[ppp_pkg::SUM_W-2:0], 1'b0};
            r_behind <= i_sums.d[ppp_pkg::SUM_W-1] || (i_sums.d == '0);
        end
        if (en_d) r_data <= n_data;
    end

    assign o_valid = r_vd;
    assign o_data  = r_data;
endmodule

FILE: sv/ppp_div_cell.sv
// One restoring-division cell: settles quotient bit K of both rows.
module ppp_div_cell #(
    parameter int K = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ppp_pkg::t_div i_data,
    input  logic          i_next_en,
    output logic          o_en,
    output logic          o_valid,
    output ppp_pkg::t_div o_data
);
    localparam int XW = ppp_pkg::MAG_W + ppp_pkg::QMAX;

    logic          r_valid;
    ppp_pkg::t_div r_data;
    ppp_pkg::t_div n_data;
    logic [XW-1:0] dsh;
    logic          ge_u;
    logic          ge_v;

    assign o_en = !r_valid || i_next_en;

    // Subtract the shifted divisor where it fits.
    assign dsh  = XW'(i_data.div) << K;
    assign ge_u = XW'(i_data.rem_u) >= dsh;
    assign ge_v = XW'(i_data.rem_v) >= dsh;
    always_comb begin
        n_data = i_data;
        if (ge_u) n_data.rem_u = i_data.rem_u - dsh[ppp_pkg::MAG_W-1:0];
        if (ge_v) n_data.rem_v = i_data.rem_v - dsh[ppp_pkg::MAG_W-1:0];
        n_data.quo_u[K] = ge_u;
        n_data.quo_v[K] = ge_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

FILE: dv/tb_pinhole_point_projection.sv
// Self-checking testbench for the pinhole point projection block.
module tb_pinhole_point_projection;

    localparam int LATENCY     = ppp_pkg::PIXEL_WIDTH_DEF + 8;
    localparam int CYCLE_LIMIT = 600000;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    ppp_pkg::t_point_in                   i_point;
    logic                                 o_valid;
    logic                                 i_stall;
    ppp_pkg::t_pixel_out                  o_pixel;
    logic                                 i_cfg_we;
    logic [ppp_pkg::CFG_IDX_W-1:0]        i_cfg_index;
    logic [2*ppp_pkg::HALF_W-1:0]         i_cfg_data;

    // Local copy of the projection setup
    logic [2*ppp_pkg::HALF_W-1:0] matrix_pairs [ppp_pkg::NUM_PAIRS];
    logic [ppp_pkg::DIM_W-1:0]    img_width;
    logic [ppp_pkg::DIM_W-1:0]    img_height;

    ppp_pkg::t_pixel_out pending_pixels [$];
    int         mismatches;
    int         pixels_seen;
    int         points_sent;
    int         behind_seen;
    int         inside_seen;
    int         cycle_count;
    int         hold_off_cycles;
    bit         no_idle;

    pinhole_point_projection dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_point     (i_point),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel     (o_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint matrix_coef(int row, int col);
        logic [ppp_pkg::HALF_W-1:0] half;
        longint                     c;
        half = col[0] ? matrix_pairs[row*2 + col/2][2*ppp_pkg::HALF_W-1:ppp_pkg::HALF_W]
                      : matrix_pairs[row*2 + col/2][ppp_pkg::HALF_W-1:0];
        c = $signed(half);
        return c;
    endfunction

    function automatic longint row_total(int row, longint x, longint y, longint z);
        return matrix_coef(row, 0) * x + matrix_coef(row, 1) * y
             + matrix_coef(row, 2) * z + (matrix_coef(row, 3) <<< ppp_pkg::POINT_FRAC);
    endfunction

    // floor(n/d + 1/2) for positive d
    function automatic longint nearest_div(longint n, longint d);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (r < 0) begin
            q = q - 1;
            r = r + d;
        end
        if (r >= d - r)
            q = q + 1;
        return q;
    endfunction

    function automatic logic [ppp_pkg::PIXEL_FLD_W-1:0] clamp_pixel(longint p);
        if (p > 32767)
            return 16'sh7FFF;
        if (p < -32768)
            return 16'sh8000;
        return p[ppp_pkg::PIXEL_FLD_W-1:0];
    endfunction

    function automatic ppp_pkg::t_pixel_out project_point(ppp_pkg::t_point_in pt);
        ppp_pkg::t_pixel_out px;
        longint     x;
        longint     y;
        longint     z;
        longint     nu;
        longint     nv;
        longint     dep;
        longint     u;
        longint     v;
        x   = pt.point_x;
        y   = pt.point_y;
        z   = pt.point_z;
        nu  = row_total(0, x, y, z);
        nv  = row_total(1, x, y, z);
        dep = row_total(2, x, y, z);
        px  = '0;
        if (dep <= 0) begin
            px.behind_camera = 1'b1;
            return px;
        end
        u = nearest_div(nu, dep);
        v = nearest_div(nv, dep);
        px.pixel_u  = clamp_pixel(u);
        px.pixel_v  = clamp_pixel(v);
        px.in_image = (u >= 0) && (u < longint'(img_width)) &&
                      (v >= 0) && (v < longint'(img_height));
        return px;
    endfunction

    // Receive side: compare each pixel beat, then pick the next stall
    always @(posedge i_clk) begin
        ppp_pkg::t_pixel_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            pixels_seen <= pixels_seen + 1;
            if (pending_pixels.size() == 0) begin
                mismatches = mismatches + 1;
                $display("%0t: pixel beat expected none got %h", $time, o_pixel);
            end else begin
                want = pending_pixels.pop_front();
                if (want.behind_camera) behind_seen <= behind_seen + 1;
                if (want.in_image) inside_seen <= inside_seen + 1;
                if (o_pixel.pixel_u !== want.pixel_u) begin
                    mismatches = mismatches + 1;
                    $display("%0t: pixel_u expected %0d got %0d", $time,
                             want.pixel_u, o_pixel.pixel_u);
                end
                if (o_pixel.pixel_v !== want.pixel_v) begin
                    mismatches = mismatches + 1;
                    $display("%0t: pixel_v expected %0d got %0d", $time,
                             want.pixel_v, o_pixel.pixel_v);
                end
                if (o_pixel.in_image !== want.in_image) begin
                    mismatches = mismatches + 1;
                    $display("%0t: in_image expected %b got %b", $time,
                             want.in_image, o_pixel.in_image);
                end
                if (o_pixel.behind_camera !== want.behind_camera) begin
                    mismatches = mismatches + 1;
                    $display("%0t: behind_camera expected %b got %b", $time,
                             want.behind_camera, o_pixel.behind_camera);
                end
            end
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_stall <= 1'b1;
        end else if (no_idle) begin
            i_stall <= 1'b0;
        end else if (i_stall) begin
            i_stall <= ($urandom_range(0, 99) < 70);
        end else begin
            i_stall <= ($urandom_range(0, 99) < 15);
        end
    end

    // Offer one point beat and hold it until taken
    task automatic send_point(ppp_pkg::t_point_in pt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point <= pt;
        do @(posedge i_clk); while (o_stall);
        pending_pixels.insert(pending_pixels.size(), project_point(pt));
        points_sent++;
    endtask

    task automatic send_xyz(int x, int y, int z);
        ppp_pkg::t_point_in pt;
        pt.point_x = ppp_pkg::POINT_FLD_W'(x);
        pt.point_y = ppp_pkg::POINT_FLD_W'(y);
        pt.point_z = ppp_pkg::POINT_FLD_W'(z);
        send_point(pt);
    endtask

    // Drop valid and wait for the pipeline to empty
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
    endtask

    task automatic write_reg(ppp_pkg::t_cfg_idx idx, logic [2*ppp_pkg::HALF_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == ppp_pkg::CFG_WIDTH)
            img_width = val[ppp_pkg::DIM_W-1:0];
        else if (idx == ppp_pkg::CFG_HEIGHT)
            img_height = val[ppp_pkg::DIM_W-1:0];
        else
            matrix_pairs[idx] = val;
        @(posedge i_clk);
    endtask

    function automatic logic [2*ppp_pkg::HALF_W-1:0] pack_pair(int lo, int hi);
        return {hi[ppp_pkg::HALF_W-1:0], lo[ppp_pkg::HALF_W-1:0]};
    endfunction

    // Load a plausible camera: focal lengths, centre, mild rotation and offset
    task automatic load_camera(int w, int h);
        int fx;
        int fy;
        int cx;
        int cy;
        fx = $urandom_range(100, 1500) * 4096;
        fy = fx + $urandom_range(0, 8192) - 4096;
        cx = $urandom_range(0, w) * 4096;
        cy = $urandom_range(0, h) * 4096;
        write_reg(ppp_pkg::CFG_PAIR0, pack_pair(fx, $urandom_range(0, 20000) - 10000));
        write_reg(ppp_pkg::CFG_PAIR1, pack_pair(cx, $urandom_range(0, 400000) - 200000));
        write_reg(ppp_pkg::CFG_PAIR2, pack_pair($urandom_range(0, 20000) - 10000, fy));
        write_reg(ppp_pkg::CFG_PAIR3, pack_pair(cy, $urandom_range(0, 400000) - 200000));
        write_reg(ppp_pkg::CFG_PAIR4, pack_pair($urandom_range(0, 200) - 100,
                                                $urandom_range(0, 200) - 100));
        write_reg(ppp_pkg::CFG_PAIR5, pack_pair(4096, $urandom_range(0, 2000) - 1000));
        write_reg(ppp_pkg::CFG_WIDTH, (2*ppp_pkg::HALF_W)'(w));
        write_reg(ppp_pkg::CFG_HEIGHT, (2*ppp_pkg::HALF_W)'(h));
    endtask

    // Mostly points in front at sensible range, some behind, some raw noise
    task automatic send_scene_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            send_xyz($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                     $urandom_range(500, 100000));
        else if (r < 85)
            send_xyz($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                     -$urandom_range(0, 100000));
        else
            send_xyz($urandom_range(0, 24'hFFFFFF) - 8388608,
                     $urandom_range(0, 24'hFFFFFF) - 8388608,
                     $urandom_range(0, 24'hFFFFFF) - 8388608);
    endtask

    // Zero matrix after reset: every point lies on the camera plane
    task automatic test_reset_state();
        send_xyz(0, 0, 0);
        send_xyz(1000, -1000, 5000);
        send_xyz(8388607, 8388607, 8388607);
        drain();
    endtask

    // Field extremes, rounding ties, saturation and image edges
    task automatic test_directed();
        // u = t / (4z), v likewise; depth = z
        write_reg(ppp_pkg::CFG_PAIR0, pack_pair(0, 0));
        write_reg(ppp_pkg::CFG_PAIR1, pack_pair(0, 2));
        write_reg(ppp_pkg::CFG_PAIR2, pack_pair(0, 0));
        write_reg(ppp_pkg::CFG_PAIR3, pack_pair(0, -2));
        write_reg(ppp_pkg::CFG_PAIR4, pack_pair(0, 0));
        write_reg(ppp_pkg::CFG_PAIR5, pack_pair(4096, 0));
        send_xyz(0, 0, 1);
        send_xyz(0, 0, 0);
        send_xyz(0, 0, -1);
        drain();
        // Saturation and edge pixels with unit focal length on x and y
        write_reg(ppp_pkg::CFG_PAIR0, pack_pair(4096, 0));
        write_reg(ppp_pkg::CFG_PAIR1, pack_pair(0, 0));
        write_reg(ppp_pkg::CFG_PAIR2, pack_pair(0, 4096));
        write_reg(ppp_pkg::CFG_PAIR3, pack_pair(0, 0));
        send_xyz(8388607, -8388608, 1);
        send_xyz(-8388608, 8388607, 1);
        send_xyz(639, 479, 1);
        send_xyz(640, 479, 1);
        send_xyz(639, 480, 1);
        send_xyz(-1, 0, 2);
        send_xyz(0, 0, 8388607);
        send_xyz(8388607, 8388607, -8388608);
        send_xyz(1279, 959, 2);
        drain();
        // Extreme coefficients in every slot
        for (int i = 0; i < ppp_pkg::NUM_PAIRS; i++)
            write_reg(ppp_pkg::t_cfg_idx'(i), {32'h8000_0000, 32'h7FFF_FFFF});
        send_xyz(8388607, 8388607, 8388607);
        send_xyz(-8388608, -8388608, -8388608);
        send_xyz(1, -1, 1);
        drain();
        for (int i = 0; i < ppp_pkg::NUM_PAIRS; i++)
            write_reg(ppp_pkg::t_cfg_idx'(i), {32'h7FFF_FFFF, 32'h8000_0000});
        send_xyz(-8388608, 8388607, -8388608);
        send_xyz(0, 0, 0);
        drain();
    endtask

    // Random cameras across image sizes, extremes included
    task automatic test_random_scenes();
        int sizes [6][2];
        sizes = '{'{640, 480}, '{1, 1}, '{32767, 32767}, '{0, 480},
                  '{1920, 0}, '{4000, 3000}};
        for (int s = 0; s < 12; s++) begin
            no_idle = (s % 4 == 3);
            if (s < 6)
                load_camera(sizes[s][0], sizes[s][1]);
            else
                load_camera($urandom_range(1, 32767), $urandom_range(1, 32767));
            repeat (90) send_scene_point();
            drain();
        end
        no_idle = 1'b0;
    endtask

    // Full random matrices and points for bit coverage
    task automatic test_wild_matrix();
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < ppp_pkg::NUM_PAIRS; i++)
                write_reg(ppp_pkg::t_cfg_idx'(i), {$urandom(), $urandom()});
            repeat (40)
                send_xyz($urandom_range(0, 24'hFFFFFF) - 8388608,
                         $urandom_range(0, 24'hFFFFFF) - 8388608,
                         $urandom_range(0, 24'hFFFFFF) - 8388608);
            drain();
        end
    endtask

    // Long receiver hold-off while points keep coming, then a full pause
    task automatic test_backpressure();
        load_camera(640, 480);
        @(posedge i_clk);
        hold_off_cycles <= 300;
        no_idle = 1'b1;
        repeat (120) send_scene_point();
        no_idle = 1'b0;
        drain();
        repeat (60) send_scene_point();
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_point         = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        mismatches      = 0;
        pixels_seen     = 0;
        points_sent     = 0;
        behind_seen     = 0;
        inside_seen     = 0;
        cycle_count     = 0;
        hold_off_cycles = 0;
        no_idle         = 1'b0;
        for (int i = 0; i < ppp_pkg::NUM_PAIRS; i++)
            matrix_pairs[i] = '0;
        img_width  = ppp_pkg::WIDTH_RST;
        img_height = ppp_pkg::HEIGHT_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed();
        test_random_scenes();
        test_wild_matrix();
        test_backpressure();

        $display("projected %0d points, %0d pixels checked (%0d behind camera, %0d in image)",
                 points_sent, pixels_seen, behind_seen, inside_seen);
        $display("covered rounding ties, saturation, image edges, zero sizes and long stalls");
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
